// ===== src/pdcc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcc_pkg
// shared widths, command/status bundles and controller states for the
// pwm duty-cycle capture block
// ----------------------------------------------------------------------------
package pdcc_pkg;

  localparam int TIME_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int DUTY_WIDTH = FRAC_BITS + 1;
  localparam int REG_WIDTH  = 32;
  localparam int ADDR_WIDTH = 3;
  localparam int STEP_W     = $clog2(FRAC_BITS);

  localparam logic [STEP_W-1:0]     STEP_LAST = STEP_W'(FRAC_BITS - 1);
  localparam logic [DUTY_WIDTH-1:0] DUTY_ONE  = DUTY_WIDTH'(1) << FRAC_BITS;

  localparam logic REG_MIN_PERIOD = 1'b0;
  localparam logic REG_MAX_PERIOD = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EVAL = 4'b0010,
    S_DIV  = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  typedef struct packed {
    logic capture;
    logic eval;
    logic step;
    logic load;
  } cmd_t;

  typedef struct packed {
    logic rising;
    logic window_ok;
    logic clamp;
    logic out_free;
  } status_t;

endpackage

// ===== src/pdcc_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcc_if
// valid/ready channels for edge events and duty readings
// ----------------------------------------------------------------------------
interface pdcc_edge_if;
  logic                           valid;
  logic                           ready;
  logic [pdcc_pkg::TIME_WIDTH-1:0] edge_time;
  logic                           edge_level;

  modport source (output valid, output edge_time, output edge_level, input ready);
  modport sink (input valid, input edge_time, input edge_level, output ready);
endinterface

interface pdcc_duty_if;
  logic                            valid;
  logic                            ready;
  logic [pdcc_pkg::DUTY_WIDTH-1:0] duty_fraction;
  logic [pdcc_pkg::TIME_WIDTH-1:0] sample_time;

  modport source (output valid, output duty_fraction, output sample_time, input ready);
  modport sink (input valid, input duty_fraction, input sample_time, output ready);
endinterface

// ===== src/pwm_duty_cycle_capture_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_duty_cycle_capture_core
// pwm input capture: duty cycle from edge timestamps, apb window registers
// ----------------------------------------------------------------------------
// A rising edge beat is accepted and evaluated. A falling edge beat that is
// dropped is accepted and evaluated; one that yields a reading is accepted,
// evaluated, taken through 16 divide steps and loaded, the restoring divider
// producing one fraction bit per cycle; a reading at or above 1.0 skips
// the divider and goes straight to load. The finished reading sits in an output
// register, so the next edge is taken while it waits; a further reading is
// held in the divider until the output register is free.
// Registers: 0x0 min_period_ticks (reset 0), 0x4 max_period_ticks
// (reset 0xffffffff). Write them only while the block is idle.
// ----------------------------------------------------------------------------
module pwm_duty_cycle_capture_core (
  input  logic                            clk,
  input  logic                            rst,
  pdcc_edge_if.sink                       edge_in,
  pdcc_duty_if.source                     duty_out,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [pdcc_pkg::ADDR_WIDTH-1:0] paddr,
  input  logic [pdcc_pkg::REG_WIDTH-1:0]  pwdata,
  output logic [pdcc_pkg::REG_WIDTH-1:0]  prdata,
  output logic                            pready
);

  pdcc_pkg::cmd_t                 cmd;
  pdcc_pkg::status_t              status;
  logic                           in_ready;
  logic                           wr_en;
  logic                           reg_sel;
  logic [pdcc_pkg::REG_WIDTH-1:0] min_period_ticks;
  logic [pdcc_pkg::REG_WIDTH-1:0] max_period_ticks;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;
  assign prdata  = (reg_sel == pdcc_pkg::REG_MAX_PERIOD) ? max_period_ticks
                                                          : min_period_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_period_ticks <= '0;
      max_period_ticks <= '1;
    end else if (wr_en) begin
      case (reg_sel)
        pdcc_pkg::REG_MIN_PERIOD: min_period_ticks <= pwdata;
        pdcc_pkg::REG_MAX_PERIOD: max_period_ticks <= pwdata;
        default: begin
          min_period_ticks <= min_period_ticks;
        end
      endcase
    end
  end

  assign edge_in.ready = in_ready;

  pdcc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (edge_in.valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  pdcc_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .edge_time        (edge_in.edge_time),
    .edge_level       (edge_in.edge_level),
    .min_period_ticks (min_period_ticks),
    .max_period_ticks (max_period_ticks),
    .out_valid        (duty_out.valid),
    .out_ready        (duty_out.ready),
    .duty_fraction    (duty_out.duty_fraction),
    .sample_time      (duty_out.sample_time)
  );

endmodule

// ===== src/pdcc_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcc_ctrl
// sequencer: accept an edge, evaluate it, run the divider, load the result
// ----------------------------------------------------------------------------
module pdcc_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  pdcc_pkg::status_t status,
  output pdcc_pkg::cmd_t    cmd
);

  pdcc_pkg::state_t                state;
  pdcc_pkg::state_t                state_next;
  logic [pdcc_pkg::STEP_W-1:0]     cnt;
  logic [pdcc_pkg::STEP_W-1:0]     cnt_next;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    in_ready    = 1'b0;
    cmd         = '0;
    case (state)
      pdcc_pkg::S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
        if (in_valid) begin
          state_next = pdcc_pkg::S_EVAL;
        end
      end
      pdcc_pkg::S_EVAL: begin
        cmd.eval = 1'b1;
        cnt_next = '0;
        if (status.rising || !status.window_ok) begin
          state_next = pdcc_pkg::S_IDLE;
        end else if (status.clamp) begin
          state_next = pdcc_pkg::S_LOAD;
        end else begin
          state_next = pdcc_pkg::S_DIV;
        end
      end
      pdcc_pkg::S_DIV: begin
        cmd.step = 1'b1;
        cnt_next = cnt + 1'b1;
        if (cnt == pdcc_pkg::STEP_LAST) begin
          state_next = pdcc_pkg::S_LOAD;
        end
      end
      pdcc_pkg::S_LOAD: begin
        if (status.out_free) begin
          cmd.load   = 1'b1;
          state_next = pdcc_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = pdcc_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pdcc_pkg::S_IDLE;
      cnt   <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
    end
  end

  a_load_needs_slot: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> status.out_free)
    else $error("result loaded into occupied output slot");

  a_div_length: assert property (@(posedge clk) disable iff (rst)
    (state == pdcc_pkg::S_DIV && cnt == pdcc_pkg::STEP_LAST) |=> state == pdcc_pkg::S_LOAD)
    else $error("divider did not hand over after last step");

  a_capture_eval: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |=> (state == pdcc_pkg::S_EVAL && !in_ready))
    else $error("captured edge not evaluated next cycle");

endmodule

// ===== src/pdcc_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdcc_dp
// timing state, window check, bit-serial fraction divider and output slot
// ----------------------------------------------------------------------------
module pdcc_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  pdcc_pkg::cmd_t                  cmd,
  output pdcc_pkg::status_t               status,
  input  logic [pdcc_pkg::TIME_WIDTH-1:0] edge_time,
  input  logic                            edge_level,
  input  logic [pdcc_pkg::REG_WIDTH-1:0]  min_period_ticks,
  input  logic [pdcc_pkg::REG_WIDTH-1:0]  max_period_ticks,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [pdcc_pkg::DUTY_WIDTH-1:0] duty_fraction,
  output logic [pdcc_pkg::TIME_WIDTH-1:0] sample_time
);

  logic [pdcc_pkg::TIME_WIDTH-1:0] ev_time;
  logic                            ev_level;
  logic                            seen_rising;
  logic [pdcc_pkg::TIME_WIDTH-1:0] period_start;
  logic [pdcc_pkg::TIME_WIDTH-1:0] pulse_start;
  logic [pdcc_pkg::TIME_WIDTH-1:0] last_period;
  logic [pdcc_pkg::TIME_WIDTH-1:0] rem;
  logic [pdcc_pkg::DUTY_WIDTH-1:0] quo;
  logic [pdcc_pkg::TIME_WIDTH-1:0] width;
  logic [pdcc_pkg::TIME_WIDTH:0]   trial;
  logic                            trial_ge;
  logic                            period_in_window;

  assign width = ev_time - pulse_start;
  assign trial = {rem, 1'b0};
  assign trial_ge = trial >= {1'b0, last_period};

  assign period_in_window = (last_period != '0)
                         && ({{(pdcc_pkg::REG_WIDTH){1'b0}}, last_period}
                             >= {{(pdcc_pkg::TIME_WIDTH){1'b0}}, min_period_ticks})
                         && ({{(pdcc_pkg::REG_WIDTH){1'b0}}, last_period}
                             <= {{(pdcc_pkg::TIME_WIDTH){1'b0}}, max_period_ticks});

  always_comb begin
    status.rising    = ev_level;
    status.window_ok = seen_rising && period_in_window;
    status.clamp     = width >= last_period;
    status.out_free  = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ev_time  <= edge_time;
      ev_level <= edge_level;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_rising  <= 1'b0;
      period_start <= '0;
      pulse_start  <= '0;
      last_period  <= '0;
    end else if (cmd.eval && ev_level) begin
      if (seen_rising) begin
        last_period <= ev_time - period_start;
      end
      seen_rising  <= 1'b1;
      period_start <= ev_time;
      pulse_start  <= ev_time;
    end
  end

  // restoring division, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      rem <= width;
      quo <= status.clamp ? pdcc_pkg::DUTY_ONE : '0;
    end else if (cmd.step) begin
      if (trial_ge) begin
        rem <= pdcc_pkg::TIME_WIDTH'(trial - {1'b0, last_period});
        quo <= {quo[pdcc_pkg::DUTY_WIDTH-2:0], 1'b1};
      end else begin
        rem <= trial[pdcc_pkg::TIME_WIDTH-1:0];
        quo <= {quo[pdcc_pkg::DUTY_WIDTH-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      duty_fraction <= quo;
      sample_time   <= ev_time;
    end
  end

endmodule

// ===== tb/pwm_duty_cycle_capture_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_duty_cycle_capture_core_test
// edge events into the capture core, every duty reading checked in order
// against a predictor; a short table of corner edges, then random pwm trains
// under several period windows set over apb, with random idling and stalls
// ----------------------------------------------------------------------------
module pwm_duty_cycle_capture_core_test;
  import pdcc_pkg::*;

  localparam logic LVL_RISE    = 1'b1;
  localparam logic LVL_FALL    = 1'b0;
  localparam int   SETTLE      = 30;
  localparam int   QUIET_LIMIT = 4000;

  typedef struct packed {
    logic [DUTY_WIDTH-1:0] duty;
    logic [TIME_WIDTH-1:0] stamp;
  } reading_t;

  typedef struct packed {
    logic [TIME_WIDTH-1:0] stamp;
    logic                  level;
    logic                  fixed;
    logic                  has;
    logic [DUTY_WIDTH-1:0] duty;
  } edge_row_t;

  typedef struct packed {
    logic [REG_WIDTH-1:0] min_ticks;
    logic [REG_WIDTH-1:0] max_ticks;
    logic [31:0]          period_lo;
    logic [31:0]          period_hi;
    int                   count;
  } window_phase_t;

  logic                  clk;
  logic                  rst;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [ADDR_WIDTH-1:0] paddr;
  logic [REG_WIDTH-1:0]  pwdata;
  logic [REG_WIDTH-1:0]  prdata;
  logic                  pready;

  pdcc_edge_if edge_bus ();
  pdcc_duty_if duty_bus ();

  pwm_duty_cycle_capture_core dut (
    .clk      (clk),
    .rst      (rst),
    .edge_in  (edge_bus),
    .duty_out (duty_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // predictor state and window copy
  logic                  have_rising = 1'b0;
  logic [TIME_WIDTH-1:0] rise_time   = '0;
  logic [TIME_WIDTH-1:0] high_start  = '0;
  logic [TIME_WIDTH-1:0] period_len  = '0;
  logic [REG_WIDTH-1:0]  cfg_min     = '0;
  logic [REG_WIDTH-1:0]  cfg_max     = '1;

  reading_t  expected_readings [$];
  int        mismatch_count = 0;
  int        sent_edges     = 0;
  int        burst_left     = 0;
  int        quiet_cycles   = 0;
  logic [9:0] stall_cycle   = '0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [DUTY_WIDTH-1:0] duty_ratio(input logic [TIME_WIDTH-1:0] high_ticks,
                                                       input logic [TIME_WIDTH-1:0] period_ticks);
    logic [TIME_WIDTH:0]   rem;
    logic [DUTY_WIDTH-1:0] quo;
    int                    i;
    if (high_ticks >= period_ticks) return DUTY_ONE;
    rem = {1'b0, high_ticks};
    quo = '0;
    for (i = 0; i < FRAC_BITS; i++) begin
      rem = rem << 1;
      quo = quo << 1;
      if (rem >= {1'b0, period_ticks}) begin
        rem    = rem - {1'b0, period_ticks};
        quo[0] = 1'b1;
      end
    end
    return quo;
  endfunction

  function automatic void predict_edge(input logic [TIME_WIDTH-1:0] stamp, input logic level,
                                       output logic has, output logic [DUTY_WIDTH-1:0] duty);
    has  = 1'b0;
    duty = '0;
    if (level == LVL_RISE) begin
      if (have_rising) period_len = stamp - rise_time;
      have_rising = 1'b1;
      rise_time   = stamp;
      high_start  = stamp;
    end else if (have_rising && period_len != 0 &&
                 period_len >= cfg_min && period_len <= cfg_max) begin
      has  = 1'b1;
      duty = duty_ratio(stamp - high_start, period_len);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 100)
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic send_edge(input logic [TIME_WIDTH-1:0] stamp, input logic level,
                           input logic fixed, input logic fixed_has,
                           input logic [DUTY_WIDTH-1:0] fixed_duty);
    logic                  has;
    logic [DUTY_WIDTH-1:0] duty;
    reading_t              r;
    edge_bus.valid      <= 1'b1;
    edge_bus.edge_time  <= stamp;
    edge_bus.edge_level <= level;
    @(posedge clk);
    while (!edge_bus.ready) @(posedge clk);
    predict_edge(stamp, level, has, duty);
    if (fixed) begin
      has  = fixed_has;
      duty = fixed_duty;
    end
    if (has) begin
      r.duty  = duty;
      r.stamp = stamp;
      expected_readings.push_back(r);
    end
    sent_edges++;
  endtask

  task automatic pace_sender();
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 25);
      if (gap > 0) begin
        edge_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
  endtask

  task automatic drain_readings();
    edge_bus.valid <= 1'b0;
    do @(posedge clk); while (expected_readings.size() != 0);
  endtask

  task automatic write_window(input logic reg_sel, input logic [REG_WIDTH-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_MIN_PERIOD) cfg_min = value;
    else cfg_max = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] pick_period(input logic [31:0] lo, input logic [31:0] hi);
    case ($urandom_range(0, 11))
      0:       return cfg_min;
      1:       return cfg_max;
      2:       return cfg_min - 1;
      3:       return cfg_max + 1;
      4:       return $urandom();
      5:       return $urandom_range(1, 4);
      default: return $urandom_range(hi, lo);
    endcase
  endfunction

  function automatic logic [31:0] pick_high(input logic [31:0] period);
    logic [63:0] span;
    span = {32'b0, period} + 64'd1;
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return period;
      2:       return period - 1;
      3:       return period + $urandom_range(1, 100);
      default: return 32'(({32'b0, $urandom()} << 16 ^ {32'b0, $urandom()}) % span);
    endcase
  endfunction

  // reading checker
  always @(posedge clk) begin
    reading_t want;
    if (!rst && duty_bus.valid && duty_bus.ready) begin
      if (expected_readings.size() == 0) begin
        report_mismatch("unexpected reading", {duty_bus.duty_fraction, duty_bus.sample_time}, 0);
      end else begin
        want = expected_readings.pop_front();
        if (duty_bus.duty_fraction !== want.duty)
          report_mismatch("duty_fraction", duty_bus.duty_fraction, want.duty);
        if (duty_bus.sample_time !== want.stamp)
          report_mismatch("sample_time", duty_bus.sample_time, want.stamp);
      end
    end
  end

  // receiver stall pattern
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1'b1;
    case (stall_cycle[9:8])
      2'd0:    duty_bus.ready <= 1'b1;
      2'd1:    duty_bus.ready <= ($urandom_range(0, 3) != 0);
      2'd2:    duty_bus.ready <= (stall_cycle[5:0] >= 6'd40);
      default: duty_bus.ready <= stall_cycle[0];
    endcase
  end

  always @(posedge clk) begin
    if (rst || (edge_bus.valid && edge_bus.ready) || (duty_bus.valid && duty_bus.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("pwm_duty_cycle_capture_core_test: done, errors");
        $finish;
      end
    end
  end

  initial begin : stimulus
    edge_row_t             rows [$];
    window_phase_t         phases [$];
    window_phase_t         ph;
    logic [TIME_WIDTH-1:0] t;
    logic [31:0]           period;
    logic [31:0]           high;
    logic                  lvl;
    int                    target;
    int                    cycles;
    int                    c;
    int                    pick;

    rst                 <= 1'b1;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    edge_bus.valid      <= 1'b0;
    edge_bus.edge_time  <= '0;
    edge_bus.edge_level <= 1'b0;

    rows.push_back('{32'd100,        LVL_FALL, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'd1000,       LVL_RISE, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'd1500,       LVL_FALL, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'd1000,       LVL_RISE, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'd1500,       LVL_FALL, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'd3000,       LVL_RISE, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'd3500,       LVL_FALL, 1'b1, 1'b1, 17'd16384});
    rows.push_back('{32'd4000,       LVL_FALL, 1'b1, 1'b1, 17'd32768});
    rows.push_back('{32'd5000,       LVL_FALL, 1'b1, 1'b1, DUTY_ONE});
    rows.push_back('{32'd3000,       LVL_FALL, 1'b1, 1'b1, 17'd0});
    rows.push_back('{32'hffff_ff00,  LVL_RISE, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'h0000_0010,  LVL_FALL, 1'b0, 1'b0, 17'd0});
    rows.push_back('{32'h0000_0100,  LVL_RISE, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'h0000_0180,  LVL_FALL, 1'b1, 1'b1, 17'd16384});
    rows.push_back('{32'h0000_0101,  LVL_FALL, 1'b1, 1'b1, 17'd128});
    rows.push_back('{32'h0000_00ff,  LVL_FALL, 1'b1, 1'b1, DUTY_ONE});
    rows.push_back('{32'h0000_0103,  LVL_RISE, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'h0000_0104,  LVL_FALL, 1'b0, 1'b0, 17'd0});
    rows.push_back('{32'h0000_0102,  LVL_RISE, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'h0000_0102,  LVL_FALL, 1'b1, 1'b1, 17'd0});
    rows.push_back('{32'h0000_0101,  LVL_FALL, 1'b1, 1'b1, DUTY_ONE});
    rows.push_back('{32'h8000_0101,  LVL_FALL, 1'b0, 1'b0, 17'd0});
    rows.push_back('{32'h0000_0103,  LVL_RISE, 1'b1, 1'b0, 17'd0});
    rows.push_back('{32'h0000_0103,  LVL_FALL, 1'b1, 1'b1, 17'd0});
    rows.push_back('{32'h0000_0104,  LVL_FALL, 1'b1, 1'b1, DUTY_ONE});

    phases.push_back('{32'd0,         32'hffff_ffff, 32'd2,   32'd3000,  130});
    phases.push_back('{32'd100,       32'd1000,      32'd10,  32'd2000,  130});
    phases.push_back('{32'd500,       32'd500,       32'd498, 32'd502,   130});
    phases.push_back('{32'd1000,      32'd100,       32'd10,  32'd2000,  120});
    phases.push_back('{32'hffff_ffff, 32'hffff_ffff, 32'd1,   32'd64,    120});
    phases.push_back('{32'd0,         32'd0,         32'd0,   32'd16,    100});
    phases.push_back('{32'd1,         32'hffff_fffe, 32'd1,   32'd100000, 150});

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (rows[i]) begin
      pace_sender();
      send_edge(rows[i].stamp, rows[i].level, rows[i].fixed, rows[i].has, rows[i].duty);
    end

    t = $urandom();
    foreach (phases[p]) begin
      ph = phases[p];
      drain_readings();
      repeat (SETTLE) @(posedge clk);
      write_window(REG_MIN_PERIOD, ph.min_ticks);
      write_window(REG_MAX_PERIOD, ph.max_ticks);
      target = sent_edges + ph.count;
      while (sent_edges < target) begin
        pick = $urandom_range(0, 99);
        if (pick < 80) begin
          cycles = $urandom_range(1, 6);
          period = pick_period(ph.period_lo, ph.period_hi);
          high   = pick_high(period);
          for (c = 0; c < cycles; c++) begin
            pace_sender();
            send_edge(t, LVL_RISE, 1'b0, 1'b0, '0);
            if ($urandom_range(0, 9) != 0) begin
              pace_sender();
              send_edge(t + high, LVL_FALL, 1'b0, 1'b0, '0);
            end
            t = t + period;
            if ($urandom_range(0, 3) == 0) period = period + $urandom_range(0, 2) - 1;
          end
        end else if (pick < 90) begin
          if ($urandom_range(0, 1) == 0) t = $urandom();
          pace_sender();
          send_edge(t + $urandom_range(0, 4000), 1'($urandom_range(0, 1)), 1'b0, 1'b0, '0);
        end else if (pick < 96) begin
          lvl = 1'($urandom_range(0, 1));
          pace_sender();
          send_edge(t, lvl, 1'b0, 1'b0, '0);
          pace_sender();
          send_edge(t + $urandom_range(0, 3), lvl, 1'b0, 1'b0, '0);
        end else begin
          drain_readings();
        end
      end
    end

    edge_bus.valid <= 1'b0;
    while (expected_readings.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("pwm_duty_cycle_capture_core_test: done, clean");
    end else begin
      $display("pwm_duty_cycle_capture_core_test: done, errors");
    end
    $finish;
  end

endmodule
